// File: design/dtrs_pkg.sv
// Package for the dirty tile refresh scheduler: shared constants, codes,
// request and result types, and the controller/datapath interface structs.
// Depends on nothing.
package dtrs_pkg;

    localparam int NAME_ENTRIES = 1024;
    localparam int CODE_COUNT   = 256;
    localparam int OFF_W        = $clog2(NAME_ENTRIES);
    localparam int ADDR_W       = 17;
    localparam int REFRESH_W    = 6;
    localparam int CHECK_W      = 11;
    localparam int CFG_IDX_W    = 3;

    localparam logic [OFF_W-1:0] LAST_OFFSET = OFF_W'(NAME_ENTRIES - 1);

    typedef enum logic [1:0] {
        FUNC_WRITE_NAME = 2'd0,
        FUNC_MARK_CODE  = 2'd1,
        FUNC_MARK_ALL   = 2'd2,
        FUNC_VSYNC      = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NAME_BASE    = 3'd0,
        REG_COLOR_BASE   = 3'd1,
        REG_PATTERN_BASE = 3'd2,
        REG_REFRESH      = 3'd3,
        REG_CHECK        = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] entry_index;
        logic [7:0] entry_value;
        logic [7:0] dirty_code;
    } in_item_t;

    typedef struct packed {
        logic              is_tile;
        logic [4:0]        tile_col;
        logic [4:0]        tile_row;
        logic [7:0]        tile_code;
        logic [ADDR_W-1:0] color_tbl_addr;
        logic [ADDR_W-1:0] pattern_addr;
        logic              pass_done;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic zero_budget;
        logic stop;
    } dp_status_t;

endpackage

// File: design/dtrs_ctrl.sv
// Controller state machine of the dirty tile refresh scheduler.
// Depends on dtrs_pkg; drives the datapath through ctrl_cmd_t commands.
module dtrs_ctrl
    import dtrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] func,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        busy            = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
                if (start && (func == FUNC_VSYNC))
                begin
                    state_next = stat.zero_budget ? ST_STATUS : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.stop)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                cmd.emit_status = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/dtrs_datapath.sv
// Datapath of the dirty tile refresh scheduler: configuration registers,
// name table memory, dirty and working code sets, scan pointers and the
// result register. Depends on dtrs_pkg; controlled by dtrs_ctrl.
module dtrs_datapath
    import dtrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    input  in_item_t             item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output dp_status_t           stat,
    output logic                 result_strobe,
    output out_item_t            result
);

    logic [7:0] name_mem [NAME_ENTRIES];

    logic [ADDR_W-1:0]    color_base_reg;
    logic [ADDR_W-1:0]    pattern_base_reg;
    logic [REFRESH_W-1:0] refresh_limit_reg;
    logic [CHECK_W-1:0]   check_limit_reg;

    logic [CODE_COUNT-1:0] dirty_reg;
    logic [CODE_COUNT-1:0] working_reg;
    logic [OFF_W-1:0]      scan_offset_reg;
    logic [OFF_W-1:0]      rd_off_reg;
    logic [OFF_W-1:0]      p_off_reg;
    logic                  p_vld_reg;
    logic [7:0]            rd_data_reg;
    logic [REFRESH_W-1:0]  refresh_left_reg;
    logic [CHECK_W-1:0]    check_left_reg;
    logic                  done_reg;
    logic                  strobe_reg;
    out_item_t             result_reg;

    logic            vsync_start;
    logic            name_write;
    logic            hit;
    logic            wrap;
    logic            stop;
    logic            issue;
    logic [9:0]      p_off10;
    logic [OFF_W-1:0] p_off_inc;
    logic [ADDR_W-1:0] color_tbl_addr;
    logic [ADDR_W-1:0] pattern_addr;

    assign vsync_start = cmd.accept && (item.func == FUNC_VSYNC);
    assign name_write  = cmd.accept && (item.func == FUNC_WRITE_NAME)
                         && ({1'b0, item.entry_index} < 11'(NAME_ENTRIES));

    assign hit   = p_vld_reg && working_reg[rd_data_reg];
    assign wrap  = (p_off_reg == LAST_OFFSET);
    assign stop  = p_vld_reg && (wrap || (check_left_reg == CHECK_W'(1))
                   || (hit && (refresh_left_reg == REFRESH_W'(1))));
    assign issue = cmd.scan && !stop;

    assign p_off10   = 10'(p_off_reg);
    assign p_off_inc = wrap ? '0 : p_off_reg + OFF_W'(1);

    assign color_tbl_addr = {color_base_reg[ADDR_W-1:6], 6'b0}
                            + ADDR_W'(rd_data_reg[7:3]);
    assign pattern_addr   = {pattern_base_reg[ADDR_W-1:11], 11'b0}
                            + ADDR_W'({rd_data_reg, 3'b000});

    assign stat.zero_budget = (refresh_limit_reg == '0) || (check_limit_reg == '0);
    assign stat.stop        = stop;

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    always_ff @(posedge clk)
    begin
        if (name_write)
        begin
            name_mem[item.entry_index[OFF_W-1:0]] <= item.entry_value;
        end
        if (issue)
        begin
            rd_data_reg <= name_mem[rd_off_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_base_reg    <= '0;
            pattern_base_reg  <= '0;
            refresh_limit_reg <= REFRESH_W'(32);
            check_limit_reg   <= CHECK_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLOR_BASE:   color_base_reg    <= cfg_data;
                REG_PATTERN_BASE: pattern_base_reg  <= cfg_data;
                REG_REFRESH:      refresh_limit_reg <= cfg_data[REFRESH_W-1:0];
                REG_CHECK:        check_limit_reg   <= cfg_data[CHECK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg        <= '1;
            working_reg      <= '0;
            scan_offset_reg  <= '0;
            rd_off_reg       <= '0;
            p_off_reg        <= '0;
            p_vld_reg        <= 1'b0;
            refresh_left_reg <= '0;
            check_left_reg   <= '0;
            done_reg         <= 1'b0;
            strobe_reg       <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            strobe_reg <= (cmd.scan && hit) || cmd.emit_status;
            if (cmd.accept && (item.func == FUNC_MARK_CODE))
            begin
                dirty_reg[item.dirty_code] <= 1'b1;
            end
            if (cmd.accept && (item.func == FUNC_MARK_ALL))
            begin
                dirty_reg <= '1;
            end
            if (vsync_start)
            begin
                if (scan_offset_reg == '0)
                begin
                    working_reg <= dirty_reg;
                    dirty_reg   <= '0;
                end
                rd_off_reg       <= scan_offset_reg;
                refresh_left_reg <= refresh_limit_reg;
                check_left_reg   <= check_limit_reg;
                done_reg         <= 1'b0;
                p_vld_reg        <= 1'b0;
            end
            if (cmd.scan)
            begin
                p_vld_reg <= issue;
                p_off_reg <= rd_off_reg;
                if (issue)
                begin
                    rd_off_reg <= (rd_off_reg == LAST_OFFSET) ? '0 : rd_off_reg + OFF_W'(1);
                end
                if (p_vld_reg)
                begin
                    scan_offset_reg <= p_off_inc;
                    check_left_reg  <= check_left_reg - CHECK_W'(1);
                    if (wrap)
                    begin
                        done_reg <= 1'b1;
                    end
                    if (hit)
                    begin
                        refresh_left_reg          <= refresh_left_reg - REFRESH_W'(1);
                        result_reg.is_tile        <= 1'b1;
                        result_reg.tile_col       <= p_off10[4:0];
                        result_reg.tile_row       <= p_off10[9:5];
                        result_reg.tile_code      <= rd_data_reg;
                        result_reg.color_tbl_addr <= color_tbl_addr;
                        result_reg.pattern_addr   <= pattern_addr;
                        result_reg.pass_done      <= 1'b0;
                        result_reg.last           <= 1'b0;
                    end
                end
            end
            if (cmd.emit_status)
            begin
                result_reg.is_tile        <= 1'b0;
                result_reg.tile_col       <= '0;
                result_reg.tile_row       <= '0;
                result_reg.tile_code      <= '0;
                result_reg.color_tbl_addr <= '0;
                result_reg.pattern_addr   <= '0;
                result_reg.pass_done      <= done_reg;
                result_reg.last           <= 1'b1;
            end
        end
    end

endmodule

// File: design/dirty_tile_refresh_scheduler_top.sv
// Top level of the dirty tile refresh scheduler.
// Depends on dtrs_pkg, dtrs_ctrl and dtrs_datapath.
//
//   Channel   Signals                              Transfer rule
//   request   start, busy, item                    start high while busy low
//   config    cfg_we, cfg_index, cfg_data          cfg_we high, no wait
//   result    result_strobe, result                strobe high for one cycle
//
// A vsync request examines one name entry per cycle through the registered
// name memory read port. Reset is asynchronous and active low; the dirty set
// comes up all ones and the scan position at zero. The receiver cannot stall
// results.
module dirty_tile_refresh_scheduler_top
    import dtrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 result_strobe,
    output out_item_t            result
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    dtrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (item.func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dtrs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stat          (stat),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule
